@@ rtl/ppo_pkg.sv @@
// ----------------------------------------------------------------------------
// Pixel point operation package
// Shared types, register indexes, operation modes and arithmetic constants.
// ----------------------------------------------------------------------------
package ppo_pkg;

    localparam int DEFAULT_MAX_DIM = 4096;
    localparam int CFG_INDEX_W     = 3;
    localparam int CFG_DATA_W      = 24;
    localparam int CHAN_W          = 8;
    localparam int GAIN_W          = 17;

    localparam logic [GAIN_W-1:0] GAIN_UNITY      = 17'd16384;
    localparam logic [9:0]        THRESH_LIMIT    = 10'd382;
    localparam logic [CHAN_W-1:0] CHAN_MAX        = 8'd255;
    localparam logic signed [9:0] CONTRAST_CENTER = 10'sd255;
    localparam logic signed [28:0] CONTRAST_BIAS  = 29'sd4177920;

    typedef enum logic [2:0] {
        MODE_PASS      = 3'd0,
        MODE_REPLACE   = 3'd1,
        MODE_SET_RED   = 3'd2,
        MODE_SET_GREEN = 3'd3,
        MODE_SET_BLUE  = 3'd4,
        MODE_THRESHOLD = 3'd5,
        MODE_CONTRAST  = 3'd6,
        MODE_PAINT_OUT = 3'd7
    } mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MODE          = 3'd0,
        REG_MATCH_COLOR   = 3'd1,
        REG_FILL_COLOR    = 3'd2,
        REG_CONTRAST_GAIN = 3'd3,
        REG_ROW_LO        = 3'd4,
        REG_ROW_HI        = 3'd5,
        REG_COL_LO        = 3'd6,
        REG_COL_HI        = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        mode_t             mode;
        pixel_t            match_color;
        pixel_t            fill_color;
        logic [GAIN_W-1:0] contrast_gain;
    } color_cfg_t;

    // Contrast of one channel: floor(((2p-255)*gain + 255*16384) / 32768), clamped.
    function automatic logic [CHAN_W-1:0] contrast_chan(
        input logic [CHAN_W-1:0] p,
        input logic [GAIN_W-1:0] gain
    );
        logic signed [9:0]  centered;
        logic signed [27:0] prod;
        logic signed [28:0] sum;
        logic [CHAN_W-1:0]  res;
        centered = $signed({1'b0, p, 1'b0}) - CONTRAST_CENTER;
        prod     = 28'(centered) * 28'($signed({1'b0, gain}));
        sum      = {prod[27], prod} + CONTRAST_BIAS;
        if (sum[28]) begin
            res = '0;
        end else if (|sum[27:23]) begin
            res = CHAN_MAX;
        end else begin
            res = sum[22:15];
        end
        return res;
    endfunction

endpackage

@@ rtl/ppo_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// Pixel point operation configuration registers
// Holds the mode, colors, contrast gain and rectangle bounds.
// ----------------------------------------------------------------------------
module ppo_cfg_regs #(
    parameter int MAX_DIM = ppo_pkg::DEFAULT_MAX_DIM,
    parameter int BND_W   = $clog2(MAX_DIM) + 1
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ppo_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ppo_pkg::CFG_DATA_W-1:0]     cfg_data,
    output ppo_pkg::color_cfg_t                color_cfg,
    output logic [BND_W-1:0]                   row_lo,
    output logic [BND_W-1:0]                   row_hi,
    output logic [BND_W-1:0]                   col_lo,
    output logic [BND_W-1:0]                   col_hi
);

    localparam logic [BND_W-1:0] DIM_RESET = BND_W'(MAX_DIM);

    ppo_pkg::color_cfg_t color_cfg_reg;
    logic [BND_W-1:0]    row_lo_reg;
    logic [BND_W-1:0]    row_hi_reg;
    logic [BND_W-1:0]    col_lo_reg;
    logic [BND_W-1:0]    col_hi_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_cfg_reg.mode          <= ppo_pkg::MODE_PASS;
            color_cfg_reg.match_color   <= '0;
            color_cfg_reg.fill_color    <= '0;
            color_cfg_reg.contrast_gain <= ppo_pkg::GAIN_UNITY;
            row_lo_reg                  <= '0;
            row_hi_reg                  <= DIM_RESET;
            col_lo_reg                  <= '0;
            col_hi_reg                  <= DIM_RESET;
        end else if (cfg_valid) begin
            unique case (ppo_pkg::cfg_index_t'(cfg_index))
                ppo_pkg::REG_MODE: begin
                    color_cfg_reg.mode <= ppo_pkg::mode_t'(cfg_data[2:0]);
                end
                ppo_pkg::REG_MATCH_COLOR: begin
                    color_cfg_reg.match_color <= ppo_pkg::pixel_t'(cfg_data);
                end
                ppo_pkg::REG_FILL_COLOR: begin
                    color_cfg_reg.fill_color <= ppo_pkg::pixel_t'(cfg_data);
                end
                ppo_pkg::REG_CONTRAST_GAIN: begin
                    color_cfg_reg.contrast_gain <= cfg_data[ppo_pkg::GAIN_W-1:0];
                end
                ppo_pkg::REG_ROW_LO: row_lo_reg <= cfg_data[BND_W-1:0];
                ppo_pkg::REG_ROW_HI: row_hi_reg <= cfg_data[BND_W-1:0];
                ppo_pkg::REG_COL_LO: col_lo_reg <= cfg_data[BND_W-1:0];
                ppo_pkg::REG_COL_HI: col_hi_reg <= cfg_data[BND_W-1:0];
                default: ;
            endcase
        end
    end

    assign color_cfg = color_cfg_reg;
    assign row_lo    = row_lo_reg;
    assign row_hi    = row_hi_reg;
    assign col_lo    = col_lo_reg;
    assign col_hi    = col_hi_reg;

endmodule

@@ rtl/ppo_datapath.sv @@
// ----------------------------------------------------------------------------
// Pixel point operation datapath
// Computes the edited pixel for the selected mode in one combinational pass.
// ----------------------------------------------------------------------------
module ppo_datapath #(
    parameter int ROW_W = 12,
    parameter int BND_W = ROW_W + 1
) (
    input  ppo_pkg::pixel_t     pix_in,
    input  logic [ROW_W-1:0]    row,
    input  logic [ROW_W-1:0]    col,
    input  ppo_pkg::color_cfg_t color_cfg,
    input  logic [BND_W-1:0]    row_lo,
    input  logic [BND_W-1:0]    row_hi,
    input  logic [BND_W-1:0]    col_lo,
    input  logic [BND_W-1:0]    col_hi,
    output ppo_pkg::pixel_t     pix_out
);

    logic [9:0]       chan_sum;
    logic             is_match;
    logic             in_rect;
    logic [BND_W-1:0] row_ext;
    logic [BND_W-1:0] col_ext;
    ppo_pkg::pixel_t  contrast_pix;
    ppo_pkg::pixel_t  fill;

    assign fill     = color_cfg.fill_color;
    assign chan_sum = {2'b00, pix_in.red} + {2'b00, pix_in.green} + {2'b00, pix_in.blue};
    assign is_match = (pix_in == color_cfg.match_color);
    assign row_ext  = BND_W'(row);
    assign col_ext  = BND_W'(col);
    assign in_rect  = (row_ext >= row_lo) && (row_ext < row_hi) &&
                      (col_ext >= col_lo) && (col_ext < col_hi);

    assign contrast_pix.red   = ppo_pkg::contrast_chan(pix_in.red, color_cfg.contrast_gain);
    assign contrast_pix.green = ppo_pkg::contrast_chan(pix_in.green, color_cfg.contrast_gain);
    assign contrast_pix.blue  = ppo_pkg::contrast_chan(pix_in.blue, color_cfg.contrast_gain);

    always_comb begin
        pix_out = pix_in;
        unique case (color_cfg.mode)
            ppo_pkg::MODE_PASS: pix_out = pix_in;
            ppo_pkg::MODE_REPLACE: begin
                if (is_match) begin
                    pix_out = fill;
                end
            end
            ppo_pkg::MODE_SET_RED:   pix_out.red   = fill.red;
            ppo_pkg::MODE_SET_GREEN: pix_out.green = fill.green;
            ppo_pkg::MODE_SET_BLUE:  pix_out.blue  = fill.blue;
            ppo_pkg::MODE_THRESHOLD: begin
                if (chan_sum <= ppo_pkg::THRESH_LIMIT) begin
                    pix_out = '0;
                end else begin
                    pix_out = '1;
                end
            end
            ppo_pkg::MODE_CONTRAST: pix_out = contrast_pix;
            ppo_pkg::MODE_PAINT_OUT: begin
                if (!in_rect) begin
                    pix_out = fill;
                end
            end
            default: pix_out = pix_in;
        endcase
    end

endmodule

@@ rtl/pixel_point_operation_unit.sv @@
// ----------------------------------------------------------------------------
// Pixel point operation unit
// Each item is registered in the input stage, edited combinationally and
// registered again in the result stage.
// Throughput: one item per cycle while m_ready is high, set by both registers.
// Reset: synchronous active-low aresetn empties both stages and loads the
// register defaults (pass mode, unity gain, full-image rectangle).
// Applies one per-pixel edit selected by the mode register to each RGB item.
// ----------------------------------------------------------------------------
module pixel_point_operation_unit #(
    parameter int MAX_DIM = ppo_pkg::DEFAULT_MAX_DIM,
    parameter int ROW_W   = $clog2(MAX_DIM),
    parameter int BND_W   = ROW_W + 1
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ppo_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ppo_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [ppo_pkg::CHAN_W-1:0]      s_red,
    input  logic [ppo_pkg::CHAN_W-1:0]      s_green,
    input  logic [ppo_pkg::CHAN_W-1:0]      s_blue,
    input  logic [ROW_W-1:0]                s_row,
    input  logic [ROW_W-1:0]                s_col,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [ppo_pkg::CHAN_W-1:0]      m_out_red,
    output logic [ppo_pkg::CHAN_W-1:0]      m_out_green,
    output logic [ppo_pkg::CHAN_W-1:0]      m_out_blue
);

    ppo_pkg::color_cfg_t color_cfg;
    logic [BND_W-1:0]    row_lo;
    logic [BND_W-1:0]    row_hi;
    logic [BND_W-1:0]    col_lo;
    logic [BND_W-1:0]    col_hi;

    logic            in_valid_reg;
    logic            in_valid_next;
    ppo_pkg::pixel_t in_pix_reg;
    logic [ROW_W-1:0] in_row_reg;
    logic [ROW_W-1:0] in_col_reg;
    logic            out_valid_reg;
    logic            out_valid_next;
    ppo_pkg::pixel_t out_pix_reg;
    ppo_pkg::pixel_t out_pix_next;
    logic            advance;
    logic            take_in;

    ppo_cfg_regs #(
        .MAX_DIM (MAX_DIM),
        .BND_W   (BND_W)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .color_cfg (color_cfg),
        .row_lo    (row_lo),
        .row_hi    (row_hi),
        .col_lo    (col_lo),
        .col_hi    (col_hi)
    );

    ppo_datapath #(
        .ROW_W (ROW_W),
        .BND_W (BND_W)
    ) u_datapath (
        .pix_in    (in_pix_reg),
        .row       (in_row_reg),
        .col       (in_col_reg),
        .color_cfg (color_cfg),
        .row_lo    (row_lo),
        .row_hi    (row_hi),
        .col_lo    (col_lo),
        .col_hi    (col_hi),
        .pix_out   (out_pix_next)
    );

    assign advance        = !out_valid_reg || m_ready;
    assign s_ready        = !in_valid_reg || advance;
    assign take_in        = s_valid && s_ready;
    assign in_valid_next  = take_in || (in_valid_reg && !advance);
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take_in) begin
            in_pix_reg <= '{red: s_red, green: s_green, blue: s_blue};
            in_row_reg <= s_row;
            in_col_reg <= s_col;
        end
        if (advance && in_valid_reg) begin
            out_pix_reg <= out_pix_next;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_out_red   = out_pix_reg.red;
    assign m_out_green = out_pix_reg.green;
    assign m_out_blue  = out_pix_reg.blue;

    a_empty_stage_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("Input stage is empty but the input is not ready.");

    a_stage_moves_forward: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("A held item did not move into a free result register.");

    a_drain_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && m_ready && !in_valid_reg) |=> !out_valid_reg)
        else $error("A taken result was shown again.");

    a_pass_mode_exact: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_valid_reg && color_cfg.mode == ppo_pkg::MODE_PASS)
        |=> (out_pix_reg == $past(in_pix_reg)))
        else $error("Pass mode changed the pixel.");

endmodule
